/* design/sstf_pkg.sv */
// ----------------------------------------------------------------------------
// SSTF scheduler package
// Shared types, codes and helper functions of the chained file scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

    localparam int DEF_BLOCKS       = 1024;
    localparam int DEF_MAX_REQUESTS = 32;
    localparam int BLK_W            = 10;
    localparam int NB_W             = 11;
    localparam int SEEK_W           = 32;
    localparam int EXT_W            = 15;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_ADD     = 2'd1,
        CMD_STEP    = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_MISSING = 2'd1,
        STAT_NONE    = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAVE,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef enum logic {
        OP_INSERT,
        OP_SEARCH
    } wave_op_t;

    typedef struct packed {
        logic             live;
        wave_op_t         op;
        logic [BLK_W-1:0] blk;
        logic             found;
        logic [BLK_W-1:0] best_d;
        logic [BLK_W-1:0] best_blk;
    } token_t;

    typedef struct packed {
        logic             valid;
        logic             end_mark;
        logic [BLK_W-1:0] next;
    } tbl_entry_t;

    function automatic logic [BLK_W-1:0] blk_dist(input logic [BLK_W-1:0] a,
                                                  input logic [BLK_W-1:0] b);
        blk_dist = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

/* design/sstf_req_cell.sv */
// ----------------------------------------------------------------------------
// SSTF request cell
// One slot of the request store. A token passes through every cycle; an
// insert token is taken by the first empty slot, a search token keeps the
// nearest pending block seen so far.
// ----------------------------------------------------------------------------
module sstf_req_cell #(
    parameter int MAX_REQUESTS = sstf_pkg::DEF_MAX_REQUESTS,
    parameter int CELL_IDX     = 0,
    localparam int IW          = $clog2(MAX_REQUESTS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [sstf_pkg::BLK_W-1:0]  head,
    input  sstf_pkg::token_t            tok_in,
    input  logic [IW-1:0]               idx_in,
    output sstf_pkg::token_t            tok_out,
    output logic [IW-1:0]               idx_out,
    input  logic                        rm_en,
    input  logic [IW-1:0]               rm_idx
);
    import sstf_pkg::*;

    logic             valid_reg;
    logic [BLK_W-1:0] blk_reg;
    token_t           tok_reg;
    token_t           tok_next;
    logic [IW-1:0]    idx_reg;
    logic [IW-1:0]    idx_next;
    logic [BLK_W-1:0] d;
    logic             take_search;
    logic             take_insert;

    always_comb
    begin
        d = blk_dist(head, blk_reg);
        take_search = tok_in.live && (tok_in.op == OP_SEARCH) && valid_reg &&
                      (!tok_in.found || (d < tok_in.best_d) ||
                       ((d == tok_in.best_d) && (blk_reg < tok_in.best_blk)));
        take_insert = tok_in.live && (tok_in.op == OP_INSERT) && !tok_in.found &&
                      !valid_reg;
        tok_next = tok_in;
        idx_next = idx_in;
        if (take_search)
        begin
            tok_next.found    = 1'b1;
            tok_next.best_d   = d;
            tok_next.best_blk = blk_reg;
            idx_next          = IW'(CELL_IDX);
        end
        if (take_insert)
        begin
            tok_next.found = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (take_insert)
            begin
                valid_reg <= 1'b1;
            end
            else if (rm_en && (rm_idx == IW'(CELL_IDX)))
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (take_insert)
        begin
            blk_reg <= tok_in.blk;
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

`ifndef NO_ASSERTIONS
    a_no_insert_and_remove: assert property (@(posedge clk) disable iff (!rst_n)
        !(take_insert && rm_en && (rm_idx == IW'(CELL_IDX))))
        else $error("Slot filled and removed in the same cycle.");
`endif

endmodule

/* design/sstf_next_table.sv */
// ----------------------------------------------------------------------------
// SSTF next-block table
// One-write, one-read memory of chain entries with a registered read port.
// After reset a clearing pass marks every entry invalid, one per cycle.
// ----------------------------------------------------------------------------
module sstf_next_table #(
    parameter int BLOCKS = sstf_pkg::DEF_BLOCKS,
    localparam int AW    = $clog2(BLOCKS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  sstf_pkg::tbl_entry_t wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output sstf_pkg::tbl_entry_t rd_data,
    output logic                 busy
);
    import sstf_pkg::*;

    tbl_entry_t    mem [BLOCKS];
    tbl_entry_t    rd_data_reg;
    logic          busy_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    tbl_entry_t    mem_data;

    always_comb
    begin
        if (busy_reg)
        begin
            mem_we   = 1'b1;
            mem_addr = clr_addr_reg;
            mem_data = '0;
        end
        else
        begin
            mem_we   = wr_en;
            mem_addr = wr_addr;
            mem_data = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_addr_reg == AW'(BLOCKS - 1))
            begin
                busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

`ifndef NO_ASSERTIONS
    a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !busy_reg)
        else $error("Table write during the clearing pass.");
`endif

endmodule

/* design/sstf_chained_file_scheduler.sv */
// ----------------------------------------------------------------------------
// SSTF chained file scheduler
// Shortest-seek-time-first scheduler that walks chained file allocations.
//
// Input words (cmd, block, next_block) are taken when in_valid is high and
// in_stall is low. Load words fill the next-block table, add words queue a
// file start block, step words move the head to the next block of the open
// file or else to the nearest queued start block, restart words reload the
// head from start_head and clear the seek total. Every input word gives
// exactly one output word, held in an output register until out_stall is
// low; the next input word can be taken while it waits. The block works on
// one word at a time. Load, add on a full store, restart and a step with
// nothing pending go from the exec state to the emit state; a step along a
// chain reads the table on the way. An add waits in the wave state for its
// token; a step that picks a new file waits there for the search token and
// then reads the table. The token crosses the slot row one slot per cycle.
// start_head is written with cfg_wr_en. After reset, in_stall stays high
// while the table is cleared; the store is empty and the head is at block 0.
// ----------------------------------------------------------------------------
module sstf_chained_file_scheduler #(
    parameter int BLOCKS       = sstf_pkg::DEF_BLOCKS,
    parameter int MAX_REQUESTS = sstf_pkg::DEF_MAX_REQUESTS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [sstf_pkg::BLK_W-1:0]  cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  cmd,
    input  logic [sstf_pkg::BLK_W-1:0]  block,
    input  logic signed [sstf_pkg::NB_W-1:0] next_block,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [sstf_pkg::BLK_W-1:0]  visited_block,
    output logic                        first_of_file,
    output logic                        last_of_file,
    output logic                        all_done,
    output logic [sstf_pkg::SEEK_W-1:0] seek_total,
    output logic [1:0]                  status
);
    import sstf_pkg::*;

    localparam int AW = $clog2(BLOCKS);
    localparam int IW = $clog2(MAX_REQUESTS);
    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam logic [EXT_W-1:0] BLOCKS_EXT = EXT_W'(BLOCKS);

    state_t            state_reg, state_next;
    logic [BLK_W-1:0]  start_head_reg;
    cmd_t              cmd_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [NB_W-1:0]   nb_reg;
    logic [BLK_W-1:0]  head_reg, head_next;
    logic [SEEK_W-1:0] seek_reg, seek_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              cursor_valid_reg, cursor_valid_next;
    logic [BLK_W-1:0]  cursor_reg, cursor_next;
    logic [BLK_W-1:0]  target_reg, target_next;
    logic              first_reg, first_next;
    logic              last_reg, last_next;
    status_t           status_reg, status_next;

    logic              out_valid_reg;
    logic [BLK_W-1:0]  visited_reg;
    logic              first_out_reg;
    logic              last_out_reg;
    logic              done_out_reg;
    logic [SEEK_W-1:0] seek_out_reg;
    status_t           status_out_reg;

    logic              in_take;
    logic              out_load;
    logic              tbl_busy;
    logic              tbl_wr_en;
    tbl_entry_t        tbl_wr_data;
    logic              tbl_rd_en;
    logic [BLK_W-1:0]  rd_blk;
    tbl_entry_t        tbl_rd_data;
    logic [EXT_W-1:0]  wr_ext;
    logic [EXT_W-1:0]  rd_ext;
    logic [EXT_W-1:0]  target_ext;
    logic              target_ok;
    logic [BLK_W-1:0]  move_d;
    logic [SEEK_W:0]   seek_sum;
    logic              rm_en;
    logic [IW-1:0]     rm_idx;
    token_t            inject_tok;

    token_t            tok [MAX_REQUESTS+1];
    logic [IW-1:0]     idx_chain [MAX_REQUESTS+1];

    assign in_take    = in_valid && !in_stall;
    assign in_stall   = !((state_reg == ST_IDLE) && !tbl_busy);
    assign wr_ext     = EXT_W'(blk_reg);
    assign rd_ext     = EXT_W'(rd_blk);
    assign target_ext = EXT_W'(target_reg);
    assign target_ok  = (target_ext < BLOCKS_EXT) && tbl_rd_data.valid;
    assign move_d     = blk_dist(head_reg, target_reg);
    assign seek_sum   = {1'b0, seek_reg} + (SEEK_W + 1)'(move_d);

    assign tok[0]       = inject_tok;
    assign idx_chain[0] = '0;

    for (genvar g = 0; g < MAX_REQUESTS; g++)
    begin : g_cell
        sstf_req_cell #(
            .MAX_REQUESTS (MAX_REQUESTS),
            .CELL_IDX     (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .head    (head_reg),
            .tok_in  (tok[g]),
            .idx_in  (idx_chain[g]),
            .tok_out (tok[g+1]),
            .idx_out (idx_chain[g+1]),
            .rm_en   (rm_en),
            .rm_idx  (rm_idx)
        );
    end

    sstf_next_table #(
        .BLOCKS (BLOCKS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (wr_ext[AW-1:0]),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (rd_ext[AW-1:0]),
        .rd_data (tbl_rd_data),
        .busy    (tbl_busy)
    );

    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        seek_next         = seek_reg;
        count_next        = count_reg;
        cursor_valid_next = cursor_valid_reg;
        cursor_next       = cursor_reg;
        target_next       = target_reg;
        first_next        = first_reg;
        last_next         = last_reg;
        status_next       = status_reg;
        tbl_wr_en         = 1'b0;
        tbl_wr_data       = '{valid: 1'b1, end_mark: nb_reg[NB_W-1],
                              next: nb_reg[BLK_W-1:0]};
        tbl_rd_en         = 1'b0;
        rd_blk            = cursor_reg;
        rm_en             = 1'b0;
        rm_idx            = idx_chain[MAX_REQUESTS];
        inject_tok        = '0;
        inject_tok.blk    = blk_reg;
        out_load          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                first_next  = 1'b0;
                last_next   = 1'b0;
                status_next = STAT_OK;
                state_next  = ST_EMIT;
                case (cmd_reg)
                    CMD_LOAD:
                    begin
                        tbl_wr_en = (wr_ext < BLOCKS_EXT);
                    end
                    CMD_ADD:
                    begin
                        if (count_reg == CW'(MAX_REQUESTS))
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            inject_tok.live = 1'b1;
                            inject_tok.op   = OP_INSERT;
                            count_next      = count_reg + 1'b1;
                            state_next      = ST_WAVE;
                        end
                    end
                    CMD_STEP:
                    begin
                        if (cursor_valid_reg)
                        begin
                            tbl_rd_en   = 1'b1;
                            rd_blk      = cursor_reg;
                            target_next = cursor_reg;
                            state_next  = ST_READ;
                        end
                        else if (count_reg == '0)
                        begin
                            status_next = STAT_NONE;
                        end
                        else
                        begin
                            inject_tok.live = 1'b1;
                            inject_tok.op   = OP_SEARCH;
                            state_next      = ST_WAVE;
                        end
                    end
                    CMD_RESTART:
                    begin
                        head_next         = start_head_reg;
                        seek_next         = '0;
                        cursor_valid_next = 1'b0;
                    end
                    default:
                    begin
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_WAVE:
            begin
                if (tok[MAX_REQUESTS].live)
                begin
                    if (tok[MAX_REQUESTS].op == OP_SEARCH)
                    begin
                        rm_en       = 1'b1;
                        count_next  = count_reg - 1'b1;
                        first_next  = 1'b1;
                        tbl_rd_en   = 1'b1;
                        rd_blk      = tok[MAX_REQUESTS].best_blk;
                        target_next = tok[MAX_REQUESTS].best_blk;
                        state_next  = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
                if (first_reg || target_ok)
                begin
                    seek_next = seek_sum[SEEK_W] ? '1 : seek_sum[SEEK_W-1:0];
                    head_next = target_reg;
                end
                if (!target_ok)
                begin
                    cursor_valid_next = 1'b0;
                    status_next       = STAT_MISSING;
                end
                else
                begin
                    last_next         = tbl_rd_data.end_mark;
                    cursor_valid_next = !tbl_rd_data.end_mark;
                    cursor_next       = tbl_rd_data.next;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            start_head_reg   <= '0;
            head_reg         <= '0;
            seek_reg         <= '0;
            count_reg        <= '0;
            cursor_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            seek_reg         <= seek_next;
            count_reg        <= count_next;
            cursor_valid_reg <= cursor_valid_next;
            if (cfg_wr_en)
            begin
                start_head_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cursor_reg <= cursor_next;
        target_reg <= target_next;
        first_reg  <= first_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        if (in_take)
        begin
            cmd_reg <= cmd_t'(cmd);
            blk_reg <= block;
            nb_reg  <= next_block;
        end
        if (out_load)
        begin
            visited_reg    <= head_reg;
            first_out_reg  <= first_reg;
            last_out_reg   <= last_reg;
            done_out_reg   <= (count_reg == '0) && !cursor_valid_reg;
            seek_out_reg   <= seek_reg;
            status_out_reg <= status_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign visited_block = visited_reg;
    assign first_of_file = first_out_reg;
    assign last_of_file  = last_out_reg;
    assign all_done      = done_out_reg;
    assign seek_total    = seek_out_reg;
    assign status        = status_out_reg;

`ifndef NO_ASSERTIONS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_REQUESTS))
        else $error("Request count exceeds the store size.");

    a_token_only_in_wave: assert property (@(posedge clk) disable iff (!rst_n)
        tok[MAX_REQUESTS].live |-> (state_reg == ST_WAVE))
        else $error("Token left the slot row outside a search or insert.");

    a_output_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("Output word loaded outside the emit state.");

    a_remove_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        rm_en |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("Slot removal without a matching count update.");
`endif

endmodule
